// ===== rtl/mipsie_pkg.sv =====
// ----------------------------------------------------------------------------
// mipsie_pkg
// Shared types, constants and helpers for the I-type execute block.
// ----------------------------------------------------------------------------
package mipsie_pkg;

   localparam int XLEN          = 32;
   localparam int IMM_W         = 16;
   localparam int REG_COUNT     = 32;
   localparam int RIDX_W        = $clog2(REG_COUNT);
   localparam int MEM_WORDS_DEF = 1024;

   typedef enum logic [3:0] {
      OP_LW    = 4'd0,
      OP_LB    = 4'd1,
      OP_LBU   = 4'd2,
      OP_SW    = 4'd3,
      OP_ADDI  = 4'd4,
      OP_ADDIU = 4'd5,
      OP_SLTI  = 4'd6,
      OP_SLTIU = 4'd7,
      OP_ANDI  = 4'd8,
      OP_ORI   = 4'd9,
      OP_XORI  = 4'd10,
      OP_LUI   = 4'd11
   } op_type;

   // register file write port
   typedef struct packed {
      logic              en;
      logic [RIDX_W-1:0] idx;
      logic [XLEN-1:0]   data;
   } rf_wr_type;

   // data memory command
   typedef struct packed {
      logic rd;
      logic wr;
   } dmem_cmd_type;

   function automatic logic [XLEN-1:0] sext_imm(input logic [IMM_W-1:0] imm);
      return {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
   endfunction

   function automatic logic [XLEN-1:0] zext_imm(input logic [IMM_W-1:0] imm);
      return {{(XLEN-IMM_W){1'b0}}, imm};
   endfunction

   // big-endian lanes: lane 0 is the most significant byte
   function automatic logic [7:0] pick_byte(input logic [XLEN-1:0] word,
                                            input logic [1:0]      lane);
      logic [7:0] b;
      unique case (lane)
         2'd0:    b = word[31:24];
         2'd1:    b = word[23:16];
         2'd2:    b = word[15:8];
         default: b = word[7:0];
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/mips_itype_execute_top.sv =====
// ----------------------------------------------------------------------------
// mips_itype_execute_top
// MIPS32 I-type execute unit: loads, stores and immediate ALU operations
// over a 32-entry register file, a word data memory and an instruction
// counter.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  req      in         req_valid/req_stall  req_type, req_src_index,
//                                           req_dst_index, req_immediate
//  rsp      out        rsp_valid/rsp_stall  rsp_instr_count, rsp_misaligned,
//                                           rsp_reg_written,
//                                           rsp_written_index,
//                                           rsp_written_value
//
//  One transaction per cycle while rsp_stall is low and no sweep runs; a
//  result passes the register file read at the accepting edge, the data
//  memory read as it leaves stage 1, then the output register.
//  Each instruction makes at most one data memory access, so the single
//  port keeps up with this rate.
//  After reset the data memory is swept to zero, one word per cycle, and
//  req_stall stays high until the last word is cleared.
//  A stalled result holds the output register; the stages behind it keep
//  filling until no bubble remains, then req_stall rises.
//  MEM_WORDS must be a power of two; the word index wraps by bit selection.
// ----------------------------------------------------------------------------
module mips_itype_execute_top #(
   parameter int MEM_WORDS = mipsie_pkg::MEM_WORDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [3:0]                        req_type,
   input  logic [4:0]                        req_src_index,
   input  logic [4:0]                        req_dst_index,
   input  logic [15:0]                       req_immediate,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [31:0]                       rsp_instr_count,
   output logic                              rsp_misaligned,
   output logic                              rsp_reg_written,
   output logic [4:0]                        rsp_written_index,
   output logic [31:0]                       rsp_written_value
);

   localparam int XLEN   = mipsie_pkg::XLEN;
   localparam int RIDX_W = mipsie_pkg::RIDX_W;
   localparam int IMM_W  = mipsie_pkg::IMM_W;
   localparam int IDX_W  = $clog2(MEM_WORDS);

   // ------------------------------------------------------------------
   // handshake and stage movement
   // ------------------------------------------------------------------
   logic accept;
   logic p1_move;
   logic p2_move;
   logic mem_busy;

   // stage 1: operands arrive from the register file
   logic                   p1_valid_ff, p1_valid_in;
   mipsie_pkg::op_type     p1_op_ff;
   logic [RIDX_W-1:0]      p1_rs_ff;
   logic [RIDX_W-1:0]      p1_rt_ff;
   logic [IMM_W-1:0]       p1_imm_ff;

   // bypass for register writes that land while an operand waits in stage 1
   logic                   byp_s_valid_ff, byp_s_valid_in;
   logic [XLEN-1:0]        byp_s_data_ff, byp_s_data_in;
   logic                   byp_t_valid_ff, byp_t_valid_in;
   logic [XLEN-1:0]        byp_t_data_ff, byp_t_data_in;

   // stage 2: memory data arrives, writeback
   logic                   p2_valid_ff, p2_valid_in;
   mipsie_pkg::op_type     p2_op_ff;
   logic                   p2_wr_ff;
   logic [RIDX_W-1:0]      p2_idx_ff;
   logic [XLEN-1:0]        p2_val_ff;
   logic [1:0]             p2_lane_ff;
   logic                   p2_fault_ff;
   logic                   p2_adv_ff;
   logic                   p2_store_ff;

   // output register and counter
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [XLEN-1:0]        rsp_count_ff;
   logic                   rsp_mis_ff;
   logic                   rsp_wr_ff;
   logic [RIDX_W-1:0]      rsp_idx_ff;
   logic [XLEN-1:0]        rsp_val_ff;
   logic [XLEN-1:0]        pc_ff, pc_in;

   // memories
   logic [XLEN-1:0]              rf_s_data;
   logic [XLEN-1:0]              rf_t_data;
   mipsie_pkg::rf_wr_type        rf_wr;
   mipsie_pkg::dmem_cmd_type     dmem_cmd;
   logic [XLEN-1:0]              dmem_rdata;

   // stage 1 datapath
   logic [XLEN-1:0]        s_val;
   logic [XLEN-1:0]        t_val;
   logic [XLEN-1:0]        simm;
   logic [XLEN-1:0]        zimm;
   logic [XLEN-1:0]        addr;
   logic                   p1_mis;
   logic                   p1_wr;
   logic                   p1_load;
   logic                   p1_store;
   logic                   p1_adv;
   logic [XLEN-1:0]        p1_val;

   // stage 2 datapath
   logic [7:0]             ld_byte;
   logic [XLEN-1:0]        p2_final;
   logic                   p2_fwd_s;
   logic                   p2_fwd_t;

   // accept when stage 1 is free or draining and memory is not sweeping
   assign p2_move   = p2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign p1_move   = p1_valid_ff && (!p2_valid_ff || p2_move);
   assign req_stall = mem_busy || (p1_valid_ff && !p1_move);
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // memories
   // ------------------------------------------------------------------
   mipsie_regfile u_regfile (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_a_index (req_src_index),
      .rd_b_index (req_dst_index),
      .wr         (rf_wr),
      .rd_a_data  (rf_s_data),
      .rd_b_data  (rf_t_data)
   );

   mipsie_dmem #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dmem (
      .clock (clock),
      .reset (reset),
      .cmd   (dmem_cmd),
      .addr  (addr[2 +: IDX_W]),
      .wdata (t_val),
      .rdata (dmem_rdata),
      .busy  (mem_busy)
   );

   // ------------------------------------------------------------------
   // stage 2 result, also forwarded to stage 1
   // ------------------------------------------------------------------
   always_comb begin
      ld_byte = mipsie_pkg::pick_byte(dmem_rdata, p2_lane_ff);
      unique case (p2_op_ff)
         mipsie_pkg::OP_LW:  p2_final = dmem_rdata;
         mipsie_pkg::OP_LB:  p2_final = {{(XLEN-8){ld_byte[7]}}, ld_byte};
         mipsie_pkg::OP_LBU: p2_final = {{(XLEN-8){1'b0}}, ld_byte};
         default:            p2_final = p2_val_ff;
      endcase
   end

   assign p2_fwd_s = p2_valid_ff && p2_wr_ff && (p2_idx_ff == p1_rs_ff);
   assign p2_fwd_t = p2_valid_ff && p2_wr_ff && (p2_idx_ff == p1_rt_ff);

   assign rf_wr.en   = p2_move && p2_wr_ff;
   assign rf_wr.idx  = p2_idx_ff;
   assign rf_wr.data = p2_final;

   // ------------------------------------------------------------------
   // stage 1: operand select, address, ALU
   // ------------------------------------------------------------------
   always_comb begin
      // newest writer first: stage 2, then a held bypass, then the array
      priority if (p2_fwd_s) s_val = p2_final;
      else if (byp_s_valid_ff) s_val = byp_s_data_ff;
      else s_val = rf_s_data;

      priority if (p2_fwd_t) t_val = p2_final;
      else if (byp_t_valid_ff) t_val = byp_t_data_ff;
      else t_val = rf_t_data;

      simm   = mipsie_pkg::sext_imm(p1_imm_ff);
      zimm   = mipsie_pkg::zext_imm(p1_imm_ff);
      addr   = s_val + simm;
      p1_mis = (addr[1:0] != 2'b00);

      p1_wr    = 1'b0;
      p1_load  = 1'b0;
      p1_store = 1'b0;
      p1_adv   = 1'b1;
      p1_val   = '0;
      unique case (p1_op_ff)
         mipsie_pkg::OP_LW: begin
            p1_load = 1'b1;
            p1_wr   = !p1_mis;
            p1_adv  = !p1_mis;
         end
         mipsie_pkg::OP_LB,
         mipsie_pkg::OP_LBU: begin
            p1_load = 1'b1;
            p1_wr   = 1'b1;
         end
         mipsie_pkg::OP_SW: begin
            p1_store = !p1_mis;
            p1_adv   = !p1_mis;
            p1_val   = p1_mis ? '0 : t_val;
         end
         mipsie_pkg::OP_ADDI,
         mipsie_pkg::OP_ADDIU: begin
            p1_wr  = 1'b1;
            p1_val = addr;
         end
         mipsie_pkg::OP_SLTI: begin
            p1_wr  = 1'b1;
            p1_val = {{(XLEN-1){1'b0}}, ($signed(s_val) < $signed(simm))};
         end
         mipsie_pkg::OP_SLTIU: begin
            p1_wr  = 1'b1;
            p1_val = {{(XLEN-1){1'b0}}, (s_val < simm)};
         end
         mipsie_pkg::OP_ANDI: begin
            p1_wr  = 1'b1;
            p1_val = s_val & zimm;
         end
         mipsie_pkg::OP_ORI: begin
            p1_wr  = 1'b1;
            p1_val = s_val | zimm;
         end
         mipsie_pkg::OP_XORI: begin
            p1_wr  = 1'b1;
            p1_val = s_val ^ zimm;
         end
         mipsie_pkg::OP_LUI: begin
            p1_wr  = 1'b1;
            p1_val = {p1_imm_ff, {(XLEN-IMM_W){1'b0}}};
         end
         default: begin
            // unused opcode: drop it, counter holds
            p1_adv = 1'b0;
         end
      endcase

      // register zero swallows writes
      if (p1_rt_ff == '0) begin
         p1_wr = 1'b0;
      end
   end

   // loads read and aligned stores write as the instruction leaves stage 1
   assign dmem_cmd.rd = p1_move && p1_load;
   assign dmem_cmd.wr = p1_move && p1_store;

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      // stage 1 occupancy
      p1_valid_in = accept ? 1'b1 : (p1_move ? 1'b0 : p1_valid_ff);

      // capture a writeback that the array read missed or will miss
      byp_s_valid_in = byp_s_valid_ff;
      byp_s_data_in  = byp_s_data_ff;
      byp_t_valid_in = byp_t_valid_ff;
      byp_t_data_in  = byp_t_data_ff;
      if (accept) begin
         byp_s_valid_in = rf_wr.en && (rf_wr.idx == req_src_index);
         byp_t_valid_in = rf_wr.en && (rf_wr.idx == req_dst_index);
         byp_s_data_in  = rf_wr.data;
         byp_t_data_in  = rf_wr.data;
      end else if (p1_valid_ff && !p1_move) begin
         if (rf_wr.en && (rf_wr.idx == p1_rs_ff)) begin
            byp_s_valid_in = 1'b1;
            byp_s_data_in  = rf_wr.data;
         end
         if (rf_wr.en && (rf_wr.idx == p1_rt_ff)) begin
            byp_t_valid_in = 1'b1;
            byp_t_data_in  = rf_wr.data;
         end
      end

      // stage 2 occupancy
      p2_valid_in = p1_move ? 1'b1 : (p2_move ? 1'b0 : p2_valid_ff);

      // output register and counter
      rsp_valid_in = p2_move || (rsp_valid_ff && rsp_stall);
      pc_in        = p2_move ? (pc_ff + XLEN'(p2_adv_ff)) : pc_ff;
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff    <= 1'b0;
         p2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pc_ff          <= '0;
         byp_s_valid_ff <= 1'b0;
         byp_t_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff    <= p1_valid_in;
         p2_valid_ff    <= p2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         pc_ff          <= pc_in;
         byp_s_valid_ff <= byp_s_valid_in;
         byp_t_valid_ff <= byp_t_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_s_data_ff <= byp_s_data_in;
      byp_t_data_ff <= byp_t_data_in;
      if (accept) begin
         p1_op_ff  <= mipsie_pkg::op_type'(req_type);
         p1_rs_ff  <= req_src_index;
         p1_rt_ff  <= req_dst_index;
         p1_imm_ff <= req_immediate;
      end
      if (p1_move) begin
         p2_op_ff    <= p1_op_ff;
         p2_wr_ff    <= p1_wr;
         p2_idx_ff   <= p1_rt_ff;
         p2_val_ff   <= p1_val;
         p2_lane_ff  <= addr[1:0];
         p2_fault_ff <= p1_mis && ((p1_op_ff == mipsie_pkg::OP_LW) ||
                                   (p1_op_ff == mipsie_pkg::OP_SW));
         p2_adv_ff   <= p1_adv;
         p2_store_ff <= p1_store;
      end
      if (p2_move) begin
         rsp_count_ff <= pc_in;
         rsp_mis_ff   <= p2_fault_ff;
         rsp_wr_ff    <= p2_wr_ff;
         rsp_idx_ff   <= p2_wr_ff ? p2_idx_ff : '0;
         rsp_val_ff   <= p2_wr_ff ? p2_final : (p2_store_ff ? p2_val_ff : '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_instr_count   = rsp_count_ff;
   assign rsp_misaligned    = rsp_mis_ff;
   assign rsp_reg_written   = rsp_wr_ff;
   assign rsp_written_index = rsp_idx_ff;
   assign rsp_written_value = rsp_val_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // no transaction enters while the memory sweep runs
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> !accept)
      else $error("request accepted during memory clear");

   // register zero is never written back
   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      rf_wr.en |-> (rf_wr.idx != '0))
      else $error("writeback to register zero");

   // a held stage 2 blocks stage 1
   a_p2_hold_blocks_p1: assert property (@(posedge clock) disable iff (reset)
      (p2_valid_ff && !p2_move) |-> !p1_move)
      else $error("stage 1 overran a held stage 2");

   // counter holds unless an instruction retires
   a_pc_step: assert property (@(posedge clock) disable iff (reset)
      !p2_move |=> (pc_ff == $past(pc_ff)))
      else $error("counter moved without a retiring instruction");

   // a faulting access never reports a register write
   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mis_ff) |-> (!rsp_wr_ff && (rsp_val_ff == '0)))
      else $error("misaligned access reported a write");

endmodule

// ===== rtl/mipsie_regfile.sv =====
// ----------------------------------------------------------------------------
// mipsie_regfile
// 32 x 32 register file, two registered read ports, one write port.
// Per-entry valid bits make every entry read as zero after reset.
// ----------------------------------------------------------------------------
module mipsie_regfile (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rd_en,
   input  logic [mipsie_pkg::RIDX_W-1:0]       rd_a_index,
   input  logic [mipsie_pkg::RIDX_W-1:0]       rd_b_index,
   input  mipsie_pkg::rf_wr_type               wr,
   output logic [mipsie_pkg::XLEN-1:0]         rd_a_data,
   output logic [mipsie_pkg::XLEN-1:0]         rd_b_data
);

   logic [mipsie_pkg::XLEN-1:0]      regs_ff [mipsie_pkg::REG_COUNT];
   logic [mipsie_pkg::REG_COUNT-1:0] valid_ff;
   logic [mipsie_pkg::XLEN-1:0]      rd_a_ff;
   logic [mipsie_pkg::XLEN-1:0]      rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.idx] <= wr.data;
      end
   end

   // read-first: a same-cycle write is covered by the caller's bypass
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= valid_ff[rd_a_index] ? regs_ff[rd_a_index] : '0;
         rd_b_ff <= valid_ff[rd_b_index] ? regs_ff[rd_b_index] : '0;
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ===== rtl/mipsie_dmem.sv =====
// ----------------------------------------------------------------------------
// mipsie_dmem
// Word data memory, registered read, with a clearing sweep
// after reset that runs one word per cycle.
// ----------------------------------------------------------------------------
module mipsie_dmem #(
   parameter int MEM_WORDS = mipsie_pkg::MEM_WORDS_DEF,
   localparam int IDX_W    = $clog2(MEM_WORDS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mipsie_pkg::dmem_cmd_type      cmd,
   input  logic [IDX_W-1:0]              addr,
   input  logic [mipsie_pkg::XLEN-1:0]   wdata,
   output logic [mipsie_pkg::XLEN-1:0]   rdata,
   output logic                          busy
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);

   logic [mipsie_pkg::XLEN-1:0] words_ff [MEM_WORDS];
   logic [mipsie_pkg::XLEN-1:0] rdata_ff;
   logic                        busy_ff;
   logic                        busy_in;
   logic [IDX_W-1:0]            clr_idx_ff;
   logic [IDX_W-1:0]            clr_idx_in;

   always_comb begin
      busy_in    = busy_ff;
      clr_idx_in = clr_idx_ff;
      if (busy_ff) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         words_ff[clr_idx_ff] <= '0;
      end else if (cmd.wr) begin
         words_ff[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff <= words_ff[addr];
      end
   end

   assign rdata = rdata_ff;
   assign busy  = busy_ff;

endmodule

// ===== tb/sv/mips_itype_execute_top_tb.sv =====
// ----------------------------------------------------------------------------
// mips_itype_execute_top_tb
// Self-checking bench for the I-type execute unit. A directed table walks the
// field extremes, every opcode, misaligned word accesses, big-endian byte
// lanes, memory index wrap, writes to register zero and unused opcodes. A
// long random run with mostly aligned word addresses follows. Every result
// is checked against a hand-typed value or an in-bench architectural model
// of the register file, data memory and instruction counter.
// ----------------------------------------------------------------------------
module mips_itype_execute_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // Opcodes outside the defined set; the block must ignore them
   localparam logic [3:0] OP_UNUSED_LO = 4'd12;
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;

   localparam int MEM_DEPTH    = mipsie_pkg::MEM_WORDS_DEF;
   localparam int DIR_COUNT    = 25;
   localparam int RANDOM_ITEMS = 1920;
   localparam int SEGMENTS     = 8;
   localparam int PRESSURE_AT  = DIR_COUNT + 20;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 12;
   // covers the memory sweep after reset and ~2000 items, many times over
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [3:0]  op;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [15:0] imm;
   } instr_type;

   typedef struct packed {
      logic [31:0] count;
      logic        misaligned;
      logic        reg_written;
      logic [4:0]  widx;
      logic [31:0] wval;
   } result_type;

   typedef struct packed {
      instr_type  ins;
      logic       typed;   // result below is fixed by hand, not predicted
      result_type res;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_type;
   logic [4:0]  req_src_index;
   logic [4:0]  req_dst_index;
   logic [15:0] req_immediate;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_instr_count;
   logic        rsp_misaligned;
   logic        rsp_reg_written;
   logic [4:0]  rsp_written_index;
   logic [31:0] rsp_written_value;

   // Architectural state tracked alongside the block
   logic [31:0] arch_regs [32];
   logic [31:0] arch_mem [MEM_DEPTH];
   logic [31:0] arch_count;

   result_type pending_results [$];

   int sender_idle_pct = 0;
   int rcv_stall_pct   = 0;
   int issued_count    = 0;
   int checked_count   = 0;
   int fault_count     = 0;
   int ignored_count   = 0;
   int mismatch_count  = 0;
   int fail_count      = 0;
   int cycle_count     = 0;
   int hold_left       = 0;
   logic hold_done     = 1'b0;

   // Directed rows. Hand-typed results are the ones readable at a glance;
   // the rest go through the model.
   dir_row_type directed_rows [DIR_COUNT] = '{
      // lui with all-ones immediate, then lui into register zero (discarded)
      '{'{mipsie_pkg::OP_LUI,   5'd0,  5'd1,  16'hFFFF}, 1'b1,
        '{32'd1, 1'b0, 1'b1, 5'd1, 32'hFFFF0000}},
      '{'{mipsie_pkg::OP_LUI,   5'd0,  5'd0,  16'h1234}, 1'b1,
        '{32'd2, 1'b0, 1'b0, 5'd0, 32'h0}},
      // sign extension at both ends of the immediate range
      '{'{mipsie_pkg::OP_ADDIU, 5'd0,  5'd2,  16'h7FFF}, 1'b1,
        '{32'd3, 1'b0, 1'b1, 5'd2, 32'h00007FFF}},
      '{'{mipsie_pkg::OP_ADDI,  5'd0,  5'd3,  16'h8000}, 1'b1,
        '{32'd4, 1'b0, 1'b1, 5'd3, 32'hFFFF8000}},
      // add wraps past 2^32 with no trap
      '{'{mipsie_pkg::OP_ADDIU, 5'd3,  5'd5,  16'h8000}, 1'b0, '0},
      // logical immediates are zero-extended
      '{'{mipsie_pkg::OP_ORI,   5'd0,  5'd6,  16'hFFFF}, 1'b1,
        '{32'd6, 1'b0, 1'b1, 5'd6, 32'h0000FFFF}},
      '{'{mipsie_pkg::OP_ANDI,  5'd1,  5'd7,  16'hFFFF}, 1'b1,
        '{32'd7, 1'b0, 1'b1, 5'd7, 32'h0}},
      '{'{mipsie_pkg::OP_XORI,  5'd3,  5'd8,  16'hFFFF}, 1'b0, '0},
      // signed vs unsigned compares against extended immediates
      '{'{mipsie_pkg::OP_SLTI,  5'd3,  5'd9,  16'h0000}, 1'b0, '0},
      '{'{mipsie_pkg::OP_SLTIU, 5'd0,  5'd10, 16'hFFFF}, 1'b0, '0},
      '{'{mipsie_pkg::OP_SLTIU, 5'd3,  5'd11, 16'h0001}, 1'b0, '0},
      '{'{mipsie_pkg::OP_SLTI,  5'd2,  5'd12, 16'h8000}, 1'b0, '0},
      // store, then misaligned store: no counter advance
      '{'{mipsie_pkg::OP_SW,    5'd0,  5'd1,  16'h0010}, 1'b0, '0},
      '{'{mipsie_pkg::OP_SW,    5'd0,  5'd1,  16'h0011}, 1'b1,
        '{32'd13, 1'b1, 1'b0, 5'd0, 32'h0}},
      '{'{mipsie_pkg::OP_LW,    5'd0,  5'd13, 16'h0010}, 1'b0, '0},
      '{'{mipsie_pkg::OP_LW,    5'd0,  5'd14, 16'h0012}, 1'b1,
        '{32'd14, 1'b1, 1'b0, 5'd0, 32'h0}},
      // byte loads on several lanes, signed and unsigned
      '{'{mipsie_pkg::OP_LB,    5'd0,  5'd15, 16'h0010}, 1'b0, '0},
      '{'{mipsie_pkg::OP_LBU,   5'd0,  5'd16, 16'h0011}, 1'b0, '0},
      '{'{mipsie_pkg::OP_LB,    5'd0,  5'd17, 16'h0013}, 1'b0, '0},
      // negative offset on a large base; word index wraps, then alias read
      '{'{mipsie_pkg::OP_SW,    5'd1,  5'd3,  16'hFFFC}, 1'b0, '0},
      '{'{mipsie_pkg::OP_LW,    5'd0,  5'd18, 16'h0FFC}, 1'b0, '0},
      // unused opcodes: counter held, everything else zero
      '{'{OP_UNUSED_LO, 5'd5, 5'd6, 16'h1234}, 1'b1,
        '{32'd19, 1'b0, 1'b0, 5'd0, 32'h0}},
      '{'{OP_UNUSED_HI, 5'd31, 5'd31, 16'hFFFF}, 1'b1,
        '{32'd19, 1'b0, 1'b0, 5'd0, 32'h0}},
      // byte load into register zero, then top register
      '{'{mipsie_pkg::OP_LB,    5'd0,  5'd0,  16'h0010}, 1'b0, '0},
      '{'{mipsie_pkg::OP_ADDIU, 5'd31, 5'd31, 16'hFFFF}, 1'b0, '0}
   };

   mips_itype_execute_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_src_index     (req_src_index),
      .req_dst_index     (req_dst_index),
      .req_immediate     (req_immediate),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_instr_count   (rsp_instr_count),
      .rsp_misaligned    (rsp_misaligned),
      .rsp_reg_written   (rsp_reg_written),
      .rsp_written_index (rsp_written_index),
      .rsp_written_value (rsp_written_value)
   );

   always #6 clock = ~clock;

   // Advance the architectural state by one instruction and return the
   // result the block must report for it.
   function automatic result_type exec_instr(input instr_type t);
      logic [31:0] simm, base, tval, addr, word, value, stored;
      logic [7:0]  lane_byte;
      logic        wr, fault, adv;
      int          widx;
      result_type  r;
      simm      = {{16{t.imm[15]}}, t.imm};
      base      = arch_regs[t.rs];
      tval      = arch_regs[t.rt];
      addr      = base + simm;
      widx      = (addr >> 2) % MEM_DEPTH;
      word      = arch_mem[widx];
      // big-endian lanes: lane 0 sits in the top byte
      lane_byte = word[8 * (3 - addr[1:0]) +: 8];
      value     = '0;
      stored    = '0;
      wr        = 1'b0;
      fault     = 1'b0;
      adv       = 1'b1;
      case (t.op)
         mipsie_pkg::OP_LW: begin
            if (addr[1:0] != 2'd0) begin
               fault = 1'b1;
               adv   = 1'b0;
            end else begin
               value = word;
               wr    = 1'b1;
            end
         end
         mipsie_pkg::OP_LB: begin
            value = {{24{lane_byte[7]}}, lane_byte};
            wr    = 1'b1;
         end
         mipsie_pkg::OP_LBU: begin
            value = {24'd0, lane_byte};
            wr    = 1'b1;
         end
         mipsie_pkg::OP_SW: begin
            if (addr[1:0] != 2'd0) begin
               fault = 1'b1;
               adv   = 1'b0;
            end else begin
               arch_mem[widx] = tval;
               stored         = tval;
            end
         end
         mipsie_pkg::OP_ADDI, mipsie_pkg::OP_ADDIU: begin
            value = base + simm;
            wr    = 1'b1;
         end
         mipsie_pkg::OP_SLTI: begin
            value = ($signed(base) < $signed(simm)) ? 32'd1 : 32'd0;
            wr    = 1'b1;
         end
         mipsie_pkg::OP_SLTIU: begin
            value = (base < simm) ? 32'd1 : 32'd0;
            wr    = 1'b1;
         end
         mipsie_pkg::OP_ANDI: begin
            value = base & {16'd0, t.imm};
            wr    = 1'b1;
         end
         mipsie_pkg::OP_ORI: begin
            value = base | {16'd0, t.imm};
            wr    = 1'b1;
         end
         mipsie_pkg::OP_XORI: begin
            value = base ^ {16'd0, t.imm};
            wr    = 1'b1;
         end
         mipsie_pkg::OP_LUI: begin
            value = {t.imm, 16'd0};
            wr    = 1'b1;
         end
         default: adv = 1'b0;
      endcase
      // register zero stays zero: drop the write
      if (wr && t.rt == 5'd0) wr = 1'b0;
      if (wr) arch_regs[t.rt] = value;
      if (adv) arch_count = arch_count + 32'd1;
      r.count       = arch_count;
      r.misaligned  = fault;
      r.reg_written = wr;
      r.widx        = wr ? t.rt : 5'd0;
      r.wval        = wr ? value : stored;
      return r;
   endfunction

   // Random instruction. Memory ops favor a small low window so stores and
   // loads meet, and word ops are mostly aligned so they get past the fault
   // check; the rest is left as noise.
   function automatic instr_type random_instr();
      instr_type   t;
      logic [31:0] addr;
      t.op  = ($urandom_range(99) < 6)
              ? 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO))
              : 4'($urandom_range(mipsie_pkg::OP_LUI, mipsie_pkg::OP_LW));
      t.rs  = 5'($urandom_range(31));
      t.rt  = 5'($urandom_range(31));
      t.imm = 16'($urandom);
      if (t.op <= mipsie_pkg::OP_SW) begin
         if ($urandom_range(3) == 0) begin
            t.rs  = 5'd0;
            t.imm = 16'($urandom_range(63));
         end
         if ((t.op == mipsie_pkg::OP_LW || t.op == mipsie_pkg::OP_SW) &&
             $urandom_range(9) < 8) begin
            addr  = arch_regs[t.rs] + {{16{t.imm[15]}}, t.imm};
            t.imm = t.imm - {14'd0, addr[1:0]};
         end
      end
      return t;
   endfunction

   // Offer one transaction after a random gap, hold it until accepted, then
   // record what the block must answer.
   task automatic issue_instr(input instr_type t, input logic typed,
                              input result_type fixed);
      result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= t.op;
      req_src_index <= t.rs;
      req_dst_index <= t.rt;
      req_immediate <= t.imm;
      do @(posedge clock); while (req_stall);
      issued_count++;
      predicted = exec_instr(t);
      if (predicted.misaligned) fault_count++;
      if (t.op >= OP_UNUSED_LO) ignored_count++;
      pending_results.push_back(typed ? fixed : predicted);
   endtask

   // Receiver: check each accepted result, then pick the next stall value.
   // The one long hold-off lets the pipeline fill so req_stall must rise.
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_instr_count, rsp_misaligned, rsp_reg_written,
                 rsp_written_index, rsp_written_value};
         checked_count++;
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t: result with nothing outstanding: count=%h val=%h",
                     $realtime, got.count, got.wval);
         end else begin
            want = pending_results.pop_front();
            if (got.count !== want.count || got.misaligned !== want.misaligned ||
                got.reg_written !== want.reg_written || got.widx !== want.widx ||
                got.wval !== want.wval) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: result %0d mismatch", $realtime, checked_count);
                  $display("   exp count=%h mis=%b wr=%b idx=%0d val=%h",
                           want.count, want.misaligned, want.reg_written,
                           want.widx, want.wval);
                  $display("   got count=%h mis=%b wr=%b idx=%0d val=%h",
                           got.count, got.misaligned, got.reg_written,
                           got.widx, got.wval);
               end
            end
         end
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && issued_count >= PRESSURE_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding",
                  $realtime, pending_results.size());
         $display("mips_itype_execute_top_tb failed");
         $finish;
      end
   end

   initial begin
      instr_type t;
      int        seg_done;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = '0;
      req_src_index = '0;
      req_dst_index = '0;
      req_immediate = '0;
      arch_count    = '0;
      for (int i = 0; i < 32; i++) arch_regs[i] = '0;
      for (int i = 0; i < MEM_DEPTH; i++) arch_mem[i] = '0;

      // hold reset, then release it; the block then sweeps its memory while
      // req_stall is high, which the first handshake simply waits out
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_COUNT; i++)
         issue_instr(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].res);

      // Random part in segments cycling through the idle/stall mixes:
      // none, sender idle, receiver stall, both. Ignored opcodes count
      // toward a segment's length like any other transaction.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: begin sender_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin sender_idle_pct = 67; rcv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rcv_stall_pct = 67; end
            default: begin sender_idle_pct = 36; rcv_stall_pct = 36; end
         endcase
         seg_done = 0;
         while (seg_done < RANDOM_ITEMS / SEGMENTS) begin
            t = random_instr();
            issue_instr(t, 1'b0, '0);
            seg_done++;
         end
      end
      req_valid <= 1'b0;

      // drain outstanding results, then give the pipeline time to show
      // anything spurious
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fail_count += pending_results.size();

      $display("Covered %0d instructions (%0d directed), %0d misaligned word accesses,",
               issued_count, DIR_COUNT, fault_count);
      $display("%0d unused opcodes, idle/stall mixes and a %0d-cycle output hold-off.",
               ignored_count, HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("mips_itype_execute_top_tb passed");
      end else begin
         $display("%0d failures, %0d result mismatches", fail_count, mismatch_count);
         $display("mips_itype_execute_top_tb failed");
      end
      $finish;
   end

endmodule
